### src/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and constants for the quaternion vector rotator
// Fixed-point formats, request and result payloads, and the matrix item
// that travels from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package qvr_pkg;

    // Field widths and fixed-point formats.
    localparam int VEC_W      = 24;
    localparam int QUAT_W     = 16;
    localparam int QUAT_FRAC  = 15;
    localparam int QPROD_W    = 2 * QUAT_W;
    // Matrix entries span -4.0 .. +4.0 at 2*QUAT_FRAC fraction bits.
    localparam int MAT_W      = QPROD_W + 2;
    localparam int PROD_W     = MAT_W + VEC_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int MAT_FRAC   = 2 * QUAT_FRAC;
    localparam int RND_W      = ACC_W - MAT_FRAC;

    // Queue between the front and back ends.
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [VEC_W-1:0]   vec_t;
    typedef logic signed [QPROD_W-1:0] qprod_t;
    typedef logic signed [MAT_W-1:0]   mat_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [RND_W-1:0]   rnd_t;

    // One in matrix format, one half at the rounding position.
    localparam mat_t MAT_ONE  = MAT_W'(64'd1 << MAT_FRAC);
    localparam acc_t ACC_HALF = ACC_W'(64'd1 << (MAT_FRAC - 1));

    // Saturation limits of an output component.
    localparam rnd_t RND_MAX  = RND_W'((64'sd1 <<< (VEC_W - 1)) - 64'sd1);
    localparam rnd_t RND_MIN  = RND_W'(-(64'sd1 <<< (VEC_W - 1)));

    typedef enum logic [0:0] {
        OP_FORWARD = 1'b0,
        OP_INVERSE = 1'b1
    } op_t;

    typedef struct packed {
        op_t   opcode;
        quat_t quat_1;
        quat_t quat_2;
        quat_t quat_3;
        quat_t quat_4;
        vec_t  vec_x;
        vec_t  vec_y;
        vec_t  vec_z;
    } in_item_t;

    typedef struct packed {
        vec_t out_x;
        vec_t out_y;
        vec_t out_z;
        logic saturated;
    } out_item_t;

    // Matrix already oriented for the opcode, plus the vector.
    typedef struct packed {
        mat_t [2:0][2:0] m;
        vec_t [2:0]      v;
    } mat_item_t;

endpackage

### src/qvr_front.sv
// ----------------------------------------------------------------------------
// qvr_front: request intake and matrix construction
// Takes requests, forms the quaternion products, builds the rotation matrix
// and orients it by opcode, then hands the matrix item to the queue.
// ----------------------------------------------------------------------------
module qvr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  qvr_pkg::in_item_t  item,
    output logic               push_valid,
    input  logic               push_ready,
    output qvr_pkg::mat_item_t push_item
);

    // Stage one holds the quaternion products.
    logic              s1_valid_reg;
    logic              s1_valid_next;
    qvr_pkg::op_t      s1_op_reg;
    qvr_pkg::vec_t     s1_vec_reg [3];
    qvr_pkg::qprod_t   p_aa_reg, p_bb_reg, p_cc_reg;
    qvr_pkg::qprod_t   p_ab_reg, p_ac_reg, p_ad_reg;
    qvr_pkg::qprod_t   p_bc_reg, p_bd_reg, p_cd_reg;

    // Stage two holds the finished matrix item.
    logic               s2_valid_reg;
    logic               s2_valid_next;
    qvr_pkg::mat_item_t s2_item_reg;
    qvr_pkg::mat_item_t s2_item_next;

    logic              adv;
    qvr_pkg::mat_t     m00, m01, m02, m10, m11, m12, m20, m21, m22;

    // The front end moves as one whenever its last stage can drain.
    assign adv           = !s2_valid_reg || push_ready;
    assign item_ready    = adv;
    assign s1_valid_next = item_valid;
    assign s2_valid_next = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Quaternion products, one multiplier each.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg     <= item.opcode;
            s1_vec_reg[0] <= item.vec_x;
            s1_vec_reg[1] <= item.vec_y;
            s1_vec_reg[2] <= item.vec_z;
            p_aa_reg <= qvr_pkg::QPROD_W'(item.quat_1) * qvr_pkg::QPROD_W'(item.quat_1);
            p_bb_reg <= qvr_pkg::QPROD_W'(item.quat_2) * qvr_pkg::QPROD_W'(item.quat_2);
            p_cc_reg <= qvr_pkg::QPROD_W'(item.quat_3) * qvr_pkg::QPROD_W'(item.quat_3);
            p_ab_reg <= qvr_pkg::QPROD_W'(item.quat_1) * qvr_pkg::QPROD_W'(item.quat_2);
            p_ac_reg <= qvr_pkg::QPROD_W'(item.quat_1) * qvr_pkg::QPROD_W'(item.quat_3);
            p_ad_reg <= qvr_pkg::QPROD_W'(item.quat_1) * qvr_pkg::QPROD_W'(item.quat_4);
            p_bc_reg <= qvr_pkg::QPROD_W'(item.quat_2) * qvr_pkg::QPROD_W'(item.quat_3);
            p_bd_reg <= qvr_pkg::QPROD_W'(item.quat_2) * qvr_pkg::QPROD_W'(item.quat_4);
            p_cd_reg <= qvr_pkg::QPROD_W'(item.quat_3) * qvr_pkg::QPROD_W'(item.quat_4);
        end
    end

    // Rotation matrix entries from the products.
    always_comb
    begin
        m00 = qvr_pkg::MAT_ONE - (qvr_pkg::MAT_W'(p_bb_reg) <<< 1)
                               - (qvr_pkg::MAT_W'(p_cc_reg) <<< 1);
        m11 = qvr_pkg::MAT_ONE - (qvr_pkg::MAT_W'(p_aa_reg) <<< 1)
                               - (qvr_pkg::MAT_W'(p_cc_reg) <<< 1);
        m22 = qvr_pkg::MAT_ONE - (qvr_pkg::MAT_W'(p_aa_reg) <<< 1)
                               - (qvr_pkg::MAT_W'(p_bb_reg) <<< 1);
        m01 = (qvr_pkg::MAT_W'(p_ab_reg) + qvr_pkg::MAT_W'(p_cd_reg)) <<< 1;
        m10 = (qvr_pkg::MAT_W'(p_ab_reg) - qvr_pkg::MAT_W'(p_cd_reg)) <<< 1;
        m02 = (qvr_pkg::MAT_W'(p_ac_reg) - qvr_pkg::MAT_W'(p_bd_reg)) <<< 1;
        m20 = (qvr_pkg::MAT_W'(p_ac_reg) + qvr_pkg::MAT_W'(p_bd_reg)) <<< 1;
        m12 = (qvr_pkg::MAT_W'(p_bc_reg) + qvr_pkg::MAT_W'(p_ad_reg)) <<< 1;
        m21 = (qvr_pkg::MAT_W'(p_bc_reg) - qvr_pkg::MAT_W'(p_ad_reg)) <<< 1;
    end

    // Orient the matrix: inverse rotation uses the transpose.
    always_comb
    begin
        s2_item_next.v[0] = s1_vec_reg[0];
        s2_item_next.v[1] = s1_vec_reg[1];
        s2_item_next.v[2] = s1_vec_reg[2];
        s2_item_next.m[0][0] = m00;
        s2_item_next.m[1][1] = m11;
        s2_item_next.m[2][2] = m22;
        case (s1_op_reg)
            qvr_pkg::OP_INVERSE:
            begin
                s2_item_next.m[0][1] = m10;
                s2_item_next.m[0][2] = m20;
                s2_item_next.m[1][0] = m01;
                s2_item_next.m[1][2] = m21;
                s2_item_next.m[2][0] = m02;
                s2_item_next.m[2][1] = m12;
            end
            default:
            begin
                s2_item_next.m[0][1] = m01;
                s2_item_next.m[0][2] = m02;
                s2_item_next.m[1][0] = m10;
                s2_item_next.m[1][2] = m12;
                s2_item_next.m[2][0] = m20;
                s2_item_next.m[2][1] = m21;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign push_valid = s2_valid_reg;
    assign push_item  = s2_item_reg;

endmodule

### src/qvr_queue.sv
// ----------------------------------------------------------------------------
// qvr_queue: matrix item queue
// Short first-in first-out buffer that decouples the matrix front end from
// the multiply and round back end.
// ----------------------------------------------------------------------------
module qvr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  qvr_pkg::mat_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output qvr_pkg::mat_item_t pop_item
);

    qvr_pkg::mat_item_t              store_reg [qvr_pkg::Q_DEPTH];
    logic [qvr_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [qvr_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [qvr_pkg::Q_CNT_W-1:0]     count_reg, count_next;
    logic                            push;
    logic                            pop;

    assign push_ready = (count_reg != qvr_pkg::Q_CNT_W'(qvr_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = store_reg[rd_ptr_reg];

    // Pointer and occupancy update, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == qvr_pkg::Q_PTR_W'(qvr_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == qvr_pkg::Q_PTR_W'(qvr_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Occupancy never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= qvr_pkg::Q_CNT_W'(qvr_pkg::Q_DEPTH))
        else $error("queue occupancy above depth");

    // A lone push grows the occupancy by one.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue occupancy did not grow on push");

    // A lone pop shrinks the occupancy by one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue occupancy did not shrink on pop");

    // An empty queue has its pointers equal.
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

### src/qvr_back.sv
// ----------------------------------------------------------------------------
// qvr_back: matrix-vector multiply, rounding and saturation
// Multiplies the oriented matrix by the vector, sums each row, rounds to
// nearest with ties upward, saturates each component and flags clipping.
// ----------------------------------------------------------------------------
module qvr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  qvr_pkg::mat_item_t pop_item,
    output logic               result_valid,
    input  logic               result_ready,
    output qvr_pkg::out_item_t result
);

    logic               b1_valid_reg, b1_valid_next;
    logic               b2_valid_reg, b2_valid_next;
    logic               out_valid_reg, out_valid_next;
    qvr_pkg::prod_t     prod_reg [3][3];
    qvr_pkg::rnd_t      rnd_reg [3];
    qvr_pkg::rnd_t      rnd_next [3];
    qvr_pkg::acc_t      acc [3];
    qvr_pkg::vec_t      sat_val [3];
    logic [2:0]         sat_hit;
    qvr_pkg::out_item_t out_reg, out_next;
    logic               adv;

    // The back end moves as one whenever the result register can drain.
    assign adv            = !out_valid_reg || result_ready;
    assign pop_ready      = adv;
    assign b1_valid_next  = pop_valid;
    assign b2_valid_next  = b1_valid_reg;
    assign out_valid_next = b2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= b1_valid_next;
            b2_valid_reg  <= b2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Nine matrix-by-component products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= qvr_pkg::PROD_W'(pop_item.m[i][j])
                                    * qvr_pkg::PROD_W'(pop_item.v[j]);
                end
            end
        end
    end

    // Row sums with one half added, then the integer part is kept.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = qvr_pkg::ACC_W'($signed(prod_reg[i][0]))
                   + qvr_pkg::ACC_W'($signed(prod_reg[i][1]))
                   + qvr_pkg::ACC_W'($signed(prod_reg[i][2]))
                   + qvr_pkg::ACC_HALF;
            rnd_next[i] = acc[i][qvr_pkg::ACC_W-1:qvr_pkg::MAT_FRAC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rnd_reg[i] <= rnd_next[i];
            end
        end
    end

    // Clip each component to the output range.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (rnd_reg[i] > qvr_pkg::RND_MAX)
            begin
                sat_val[i] = qvr_pkg::VEC_W'(qvr_pkg::RND_MAX);
                sat_hit[i] = 1'b1;
            end
            else if (rnd_reg[i] < qvr_pkg::RND_MIN)
            begin
                sat_val[i] = qvr_pkg::VEC_W'(qvr_pkg::RND_MIN);
                sat_hit[i] = 1'b1;
            end
            else
            begin
                sat_val[i] = qvr_pkg::VEC_W'(rnd_reg[i]);
                sat_hit[i] = 1'b0;
            end
        end
        out_next.out_x     = sat_val[0];
        out_next.out_y     = sat_val[1];
        out_next.out_z     = sat_val[2];
        out_next.saturated = |sat_hit;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A flagged result has at least one component sitting at a limit.
    a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated) |->
        (result.out_x == qvr_pkg::VEC_W'(qvr_pkg::RND_MAX) ||
         result.out_x == qvr_pkg::VEC_W'(qvr_pkg::RND_MIN) ||
         result.out_y == qvr_pkg::VEC_W'(qvr_pkg::RND_MAX) ||
         result.out_y == qvr_pkg::VEC_W'(qvr_pkg::RND_MIN) ||
         result.out_z == qvr_pkg::VEC_W'(qvr_pkg::RND_MAX) ||
         result.out_z == qvr_pkg::VEC_W'(qvr_pkg::RND_MIN)))
        else $error("saturation flag without a clipped component");

    // The result register only loads while it is free or being taken.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> $stable(out_reg))
        else $error("result register changed while stalled");

    // A request popped from the queue enters the first back stage.
    a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> b1_valid_reg)
        else $error("popped request lost in back end");

endmodule

### src/quaternion_vector_rotate_core.sv
// A request passes through the two front stages (quaternion products,
// matrix), the queue and the three back stages (vector products, row sum
// and round, saturation); one request is taken per cycle when nothing
// stalls. The rate is set by these stages, which each move every cycle
// that their half can drain; a four-entry queue lets the halves stall apart.
// Reset clears all valid flags and the queue pointers; data is not reset.
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core: quaternion vector rotator
// Rotates a signed integer vector by the matrix of a Q1.15 quaternion, or by
// its transpose, with round to nearest and saturation of each component.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  qvr_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output qvr_pkg::out_item_t result
);

    logic               push_valid;
    logic               push_ready;
    qvr_pkg::mat_item_t push_item;
    logic               pop_valid;
    logic               pop_ready;
    qvr_pkg::mat_item_t pop_item;

    // Request intake and matrix construction.
    qvr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Queue between the two halves.
    qvr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Multiply, round and saturate.
    qvr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
